/* src/lld_pkg.sv */
// Shared types and constants of the least-loaded job dispatcher.
package lld_pkg;

  localparam int MaxServersDef = 16;

  localparam int TicketW = 16;
  localparam int DurW    = 16;
  localparam int SrvW    = 5;
  localparam int LoadW   = 32;
  localparam int CountW  = 5;

  // Result tdata: ticket, server number, load, padded to whole bytes.
  localparam int ResW      = TicketW + SrvW + LoadW;
  localparam int OutTdataW = ((ResW + 7) / 8) * 8;

  typedef struct packed {
    logic [DurW-1:0]    duration;
    logic [TicketW-1:0] ticket;
  } job_t;

endpackage

/* src/lld_front.sv */
// Front end: takes jobs, numbers them and computes the last server to scan.
module lld_front #(
  parameter int MaxServers = lld_pkg::MaxServersDef,
  parameter int IdxW       = 4
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_valid_i,
  input  logic [lld_pkg::CountW-1:0] cfg_data_i,
  input  logic                       job_valid_i,
  input  logic [lld_pkg::DurW-1:0]   job_duration_i,
  input  logic                       push_ready_i,
  output logic                       push_o,
  output lld_pkg::job_t              push_job_o,
  output logic [IdxW-1:0]            push_last_o
);
  import lld_pkg::*;

  localparam int CntW = $clog2(MaxServers + 1);
  localparam int CmpW = (CntW > CountW) ? CntW : CountW;

  logic [CountW-1:0]  server_count_q;
  logic [TicketW-1:0] ticket_q, ticket_d;
  logic [CmpW-1:0]    cnt_ext;

  assign push_o   = job_valid_i && push_ready_i;
  assign ticket_d = ticket_q + 1'b1;
  assign cnt_ext  = CmpW'(server_count_q);

  // A count of zero acts as one, a count above the table as the table size.
  always_comb begin
    priority if (cnt_ext > CmpW'(MaxServers)) begin
      push_last_o = IdxW'(MaxServers - 1);
    end else if (cnt_ext == '0) begin
      push_last_o = '0;
    end else begin
      push_last_o = IdxW'(cnt_ext - 1'b1);
    end
  end

  assign push_job_o.ticket   = ticket_d;
  assign push_job_o.duration = job_duration_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      server_count_q <= CountW'(1);
      ticket_q       <= '0;
    end else begin
      if (cfg_valid_i) begin
        server_count_q <= cfg_data_i;
      end
      if (push_o) begin
        ticket_q <= ticket_d;
      end
    end
  end

endmodule

/* src/lld_queue.sv */
// Two-entry queue between the front end and the dispatch engine.
module lld_queue #(
  parameter int Width = 8
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [Width-1:0] push_data_i,
  output logic             push_ready_o,
  input  logic             pop_i,
  output logic             pop_valid_o,
  output logic [Width-1:0] pop_data_o
);

  logic [Width-1:0] entry_q [2];
  logic             wr_ptr_q, rd_ptr_q;
  logic [1:0]       count_q;

  assign push_ready_o = (count_q != 2'd2);
  assign pop_valid_o  = (count_q != 2'd0);
  assign pop_data_o   = entry_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entry_q[wr_ptr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= ~wr_ptr_q;
      end
      if (pop_i) begin
        rd_ptr_q <= ~rd_ptr_q;
      end
      unique case ({push_i, pop_i})
        2'b10:   count_q <= count_q + 2'd1;
        2'b01:   count_q <= count_q - 2'd1;
        default: count_q <= count_q;
      endcase
    end
  end

endmodule

/* src/lld_back.sv */
// Dispatch engine: scans the server loads, updates the winner, holds the result.
module lld_back #(
  parameter int MaxServers = lld_pkg::MaxServersDef,
  parameter int IdxW       = 4
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          q_valid_i,
  input  lld_pkg::job_t                 q_job_i,
  input  logic [IdxW-1:0]               q_last_i,
  output logic                          q_pop_o,
  output logic                          res_valid_o,
  input  logic                          res_ready_i,
  output logic [lld_pkg::OutTdataW-1:0] res_data_o
);
  import lld_pkg::*;

  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_SCAN   = 2'd1;
  localparam logic [1:0] S_UPDATE = 2'd2;

  logic [1:0]         state_q, state_d;
  logic [LoadW-1:0]   mem [MaxServers];
  logic [MaxServers-1:0] written_q;
  logic [LoadW-1:0]   mem_rdata_q;
  logic               rd_written_q;
  logic [IdxW-1:0]    rd_idx_q, rd_addr;
  logic [LoadW-1:0]   cur_load;
  logic [LoadW-1:0]   best_load_q;
  logic [IdxW-1:0]    best_idx_q;
  logic [IdxW-1:0]    last_q;
  job_t               job_q;
  logic [LoadW:0]     sum_wide;
  logic [LoadW-1:0]   new_load;
  logic [IdxW:0]      srv_num;
  logic               res_free;
  logic               take_best;
  logic               out_load;
  logic               res_valid_q;
  logic [OutTdataW-1:0] res_data_q;

  assign res_free  = !res_valid_q || res_ready_i;
  assign q_pop_o   = (state_q == S_IDLE) && q_valid_i && res_free;
  assign cur_load  = rd_written_q ? mem_rdata_q : '0;
  assign take_best = (rd_idx_q == '0) || (cur_load < best_load_q);
  assign out_load  = (state_q == S_UPDATE);

  assign sum_wide = {1'b0, best_load_q} + (LoadW + 1)'(job_q.duration);
  assign new_load = sum_wide[LoadW] ? '1 : sum_wide[LoadW-1:0];
  assign srv_num  = {1'b0, best_idx_q} + 1'b1;

  always_comb begin
    state_d = state_q;
    rd_addr = '0;
    unique case (state_q)
      S_IDLE: begin
        if (q_pop_o) begin
          state_d = S_SCAN;
        end
      end
      S_SCAN: begin
        if (rd_idx_q == last_q) begin
          state_d = S_UPDATE;
        end else begin
          rd_addr = rd_idx_q + 1'b1;
        end
      end
      S_UPDATE: state_d = S_IDLE;
      default:  state_d = S_IDLE;
    endcase
  end

  // Load table with a registered read port; unwritten entries read as zero.
  always_ff @(posedge clk_i) begin
    mem_rdata_q <= mem[rd_addr];
    if (out_load) begin
      mem[best_idx_q] <= new_load;
    end
  end

  always_ff @(posedge clk_i) begin
    if (q_pop_o) begin
      job_q  <= q_job_i;
      last_q <= q_last_i;
    end
    if (state_q == S_SCAN && take_best) begin
      best_load_q <= cur_load;
      best_idx_q  <= rd_idx_q;
    end
    if (out_load) begin
      res_data_q <= OutTdataW'({new_load, SrvW'(srv_num), job_q.ticket});
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      written_q    <= '0;
      rd_idx_q     <= '0;
      rd_written_q <= 1'b0;
      res_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      rd_idx_q     <= rd_addr;
      rd_written_q <= written_q[rd_addr];
      if (out_load) begin
        written_q[best_idx_q] <= 1'b1;
        res_valid_q           <= 1'b1;
      end else if (res_ready_i) begin
        res_valid_q <= 1'b0;
      end
    end
  end

  assign res_valid_o = res_valid_q;
  assign res_data_o  = res_data_q;

endmodule

/* src/least_loaded_dispatch.sv */
// Least-loaded dispatcher: assigns each job to the active server with the smallest load.
// Each job scans the load table one entry per cycle, then updates the winner and registers the result.
// The engine starts a new job only once the last one is through and the output slot is free.
// A two-entry queue lets jobs be taken while a result waits on the output.
// Reset clears the ticket counter, all server loads and sets the server count to one.
// The load table needs no clearing pass: per-entry written flags make unwritten loads read zero.
module least_loaded_dispatch #(
  parameter int MAX_SERVERS = lld_pkg::MaxServersDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [lld_pkg::CountW-1:0]    cfg_data_i,    // server_count
  input  logic                          s_axis_tvalid_i,
  output logic                          s_axis_tready_o,
  input  logic [lld_pkg::DurW-1:0]      s_axis_tdata_i, // job_duration
  output logic                          m_axis_tvalid_o,
  input  logic                          m_axis_tready_i,
  // ticket_number [15:0], server_number [20:16], server_load [52:21], zero pad
  output logic [lld_pkg::OutTdataW-1:0] m_axis_tdata_o
);
  import lld_pkg::*;

  localparam int IdxW = (MAX_SERVERS > 1) ? $clog2(MAX_SERVERS) : 1;
  localparam int EntW = IdxW + $bits(job_t);

  logic            push, push_ready;
  job_t            push_job, pop_job;
  logic [IdxW-1:0] push_last, pop_last;
  logic            q_pop, q_valid;
  logic [EntW-1:0] q_out;

  assign cfg_ready_o     = 1'b1;
  assign s_axis_tready_o = push_ready;

  lld_front #(
    .MaxServers(MAX_SERVERS),
    .IdxW      (IdxW)
  ) u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_data_i    (cfg_data_i),
    .job_valid_i   (s_axis_tvalid_i),
    .job_duration_i(s_axis_tdata_i),
    .push_ready_i  (push_ready),
    .push_o        (push),
    .push_job_o    (push_job),
    .push_last_o   (push_last)
  );

  lld_queue #(
    .Width(EntW)
  ) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i ({push_last, push_job}),
    .push_ready_o(push_ready),
    .pop_i       (q_pop),
    .pop_valid_o (q_valid),
    .pop_data_o  (q_out)
  );

  assign pop_job  = q_out[$bits(job_t)-1:0];
  assign pop_last = q_out[EntW-1:$bits(job_t)];

  lld_back #(
    .MaxServers(MAX_SERVERS),
    .IdxW      (IdxW)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .q_valid_i  (q_valid),
    .q_job_i    (pop_job),
    .q_last_i   (pop_last),
    .q_pop_o    (q_pop),
    .res_valid_o(m_axis_tvalid_o),
    .res_ready_i(m_axis_tready_i),
    .res_data_o (m_axis_tdata_o)
  );

  // The engine only starts a job when the output slot is free or being drained.
  a_pop_needs_slot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop |-> (!m_axis_tvalid_o || m_axis_tready_i))
    else $error("job started while result slot occupied");

  // The engine pops only from its idle state, so two pops never follow each other.
  a_no_back_to_back_pop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop |=> !q_pop)
    else $error("engine popped two jobs in a row");

  // A delivered result always names a real, one-based server.
  a_server_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> (m_axis_tdata_o[TicketW +: SrvW] != '0))
    else $error("result carries server number zero");

endmodule

/* sim/testbench.sv */
// Self-checking testbench of the least-loaded job dispatcher, with a scoreboard class.
module testbench;
  import lld_pkg::*;

  localparam int ClkPeriod = 10;
  localparam int CycleLimit = 1_200_000;
  localparam int RandPhases = 12;
  localparam int PhaseJobs = 117;
  localparam int SettleCycles = 40;
  localparam logic [LoadW-1:0] LoadMax = '1;
  localparam logic [DurW-1:0] DurMax = '1;

  // Duration mixes of the random phases.
  typedef enum int {
    DurFull,
    DurTiny,
    DurEdges
  } dur_mix_e;

  // Field order puts the ticket in the lowest bits, as on m_axis_tdata.
  typedef struct packed {
    logic [LoadW-1:0]   load;
    logic [SrvW-1:0]    server;
    logic [TicketW-1:0] ticket;
  } grant_t;

  class dispatch_scoreboard;
    logic [LoadW-1:0]   load_of [MaxServersDef];
    logic [TicketW-1:0] last_ticket;
    logic [CountW-1:0]  server_count;
    grant_t             pending_grants[$];
    int                 errors;

    function void clear();
      foreach (load_of[i]) load_of[i] = '0;
      last_ticket = '0;
      server_count = CountW'(1);
      pending_grants.delete();
      errors = 0;
    endfunction

    // A count of zero still serves one server, and the table caps the count.
    function int active_count();
      if (server_count == 0) return 1;
      if (server_count > MaxServersDef) return MaxServersDef;
      return int'(server_count);
    endfunction

    function void note_job(logic [DurW-1:0] duration);
      int             n;
      int             best;
      logic [LoadW:0] sum;
      grant_t         g;
      n = active_count();
      best = 0;
      for (int i = 1; i < n; i++) begin
        if (load_of[i] < load_of[best]) best = i;
      end
      sum = load_of[best] + duration;
      load_of[best] = sum[LoadW] ? LoadMax : sum[LoadW-1:0];
      last_ticket = last_ticket + 1'b1;
      g.ticket = last_ticket;
      g.server = SrvW'(best + 1);
      g.load = load_of[best];
      pending_grants.insert(pending_grants.size(), g);
    endfunction

    function void check_result(grant_t got);
      grant_t want;
      if (pending_grants.size() == 0) begin
        $display("%0t: unexpected result: expected none, got ticket %0d server %0d load %0d",
                 $time, got.ticket, got.server, got.load);
        errors++;
        return;
      end
      want = pending_grants.pop_front();
      if (got.ticket != want.ticket) begin
        $display("%0t: ticket mismatch: expected %0d, got %0d", $time, want.ticket, got.ticket);
        errors++;
      end
      if (got.server != want.server) begin
        $display("%0t: server mismatch (ticket %0d): expected %0d, got %0d",
                 $time, want.ticket, want.server, got.server);
        errors++;
      end
      if (got.load != want.load) begin
        $display("%0t: load mismatch (ticket %0d): expected %0d, got %0d",
                 $time, want.ticket, want.load, got.load);
        errors++;
      end
    endfunction
  endclass

  logic                 clk;
  logic                 rst_n;
  logic                 cfg_valid;
  logic                 cfg_ready;
  logic [CountW-1:0]    cfg_data;
  logic                 s_tvalid;
  logic                 s_tready;
  logic [DurW-1:0]      s_tdata;
  logic                 m_tvalid;
  logic                 m_tready;
  logic [OutTdataW-1:0] m_tdata;

  dispatch_scoreboard jobs;
  int                 tx_idle_max;
  int                 rx_idle_max;
  int                 cycles;

  least_loaded_dispatch i_dut (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .cfg_valid_i     (cfg_valid),
    .cfg_ready_o     (cfg_ready),
    .cfg_data_i      (cfg_data),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_o (s_tready),
    .s_axis_tdata_i  (s_tdata),
    .m_axis_tvalid_o (m_tvalid),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_o  (m_tdata)
  );

  initial begin
    clk = 1'b0;
    forever #(ClkPeriod / 2) clk = ~clk;
  end

  initial begin
    cycles = 0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("FAILURE");
      $finish;
    end
  end

  task automatic send_job(input logic [DurW-1:0] duration);
    int gap;
    gap = $urandom_range(0, tx_idle_max);
    repeat (gap) begin
      @(negedge clk);
      s_tvalid <= 1'b0;
    end
    @(negedge clk);
    s_tvalid <= 1'b1;
    s_tdata <= duration;
    do @(posedge clk); while (!s_tready);
    jobs.note_job(duration);
  endtask

  // Holds the sender off until every outstanding job has come back.
  task automatic drain_jobs();
    @(negedge clk);
    s_tvalid <= 1'b0;
    while (jobs.pending_grants.size() != 0) @(negedge clk);
  endtask

  task automatic write_count(input logic [CountW-1:0] count);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= count;
    do @(posedge clk); while (!cfg_ready);
    jobs.server_count = count;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  function automatic logic [DurW-1:0] pick_duration(dur_mix_e mix);
    int roll;
    roll = $urandom_range(0, 3);
    case (mix)
      DurTiny: begin
        return DurW'($urandom_range(0, 3));
      end
      DurEdges: begin
        if (roll == 0) return '0;
        if (roll == 1) return DurMax;
        return DurW'($urandom);
      end
      default: begin
        return DurW'($urandom);
      end
    endcase
  endfunction

  // Result side: stalls a random number of cycles before each transaction.
  initial begin
    int     stall;
    grant_t got;
    m_tready = 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      stall = $urandom_range(0, rx_idle_max);
      repeat (stall) begin
        @(negedge clk);
        m_tready <= 1'b0;
      end
      @(negedge clk);
      m_tready <= 1'b1;
      do @(posedge clk); while (!m_tvalid);
      got = grant_t'(m_tdata[ResW-1:0]);
      jobs.check_result(got);
    end
  end

  initial begin
    logic [CountW-1:0] phase_counts [4];
    logic [DurW-1:0]   edge_durs [7];
    logic [CountW-1:0] count;
    dur_mix_e          mix;

    jobs = new();
    jobs.clear();
    rst_n = 1'b0;
    cfg_valid = 1'b0;
    cfg_data = '0;
    s_tvalid = 1'b0;
    s_tdata = '0;
    tx_idle_max = 7;
    rx_idle_max = 7;
    phase_counts = '{5'd16, 5'd17, 5'd3, 5'd8};
    edge_durs = '{16'd0, 16'hFFFF, 16'd1, 16'h8000, 16'h7FFF, 16'd0, 16'd0};

    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed part: the reset count first, then a zero count, then the all-ones count.
    send_job('0);
    send_job(DurMax);
    send_job(16'd1);
    drain_jobs();
    write_count('0);
    send_job(16'h5555);
    send_job(16'hAAAA);
    drain_jobs();
    write_count('1);
    foreach (edge_durs[i]) send_job(edge_durs[i]);

    for (int phase = 0; phase < RandPhases; phase++) begin
      drain_jobs();
      if (phase < 4) begin
        count = phase_counts[phase];
      end else if ($urandom_range(0, 9) == 0) begin
        count = CountW'($urandom_range(MaxServersDef + 1, 31));
      end else begin
        count = CountW'($urandom_range(1, MaxServersDef));
      end
      write_count(count);
      tx_idle_max = (phase % 4 == 3 || phase % 5 == 1) ? 0 : 7;
      rx_idle_max = (phase % 4 == 3 || phase % 5 == 2) ? 0 : 7;
      mix = dur_mix_e'(phase % 3);
      repeat (PhaseJobs) begin
        send_job(pick_duration(mix));
        if ($urandom_range(0, 199) == 0) drain_jobs();
      end
    end

    drain_jobs();
    repeat (SettleCycles) @(posedge clk);
    if (jobs.errors == 0 && jobs.pending_grants.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

/* files.f */
src/lld_pkg.sv
src/lld_front.sv
src/lld_queue.sv
src/lld_back.sv
src/least_loaded_dispatch.sv
sim/testbench.sv
